[design/paddle_end_hit_pairing_core_defines.svh]
// Assertion macros used by the paddle end hit pairing sequencer.
`ifndef PADDLE_END_HIT_PAIRING_CORE_DEFINES_SVH
`define PADDLE_END_HIT_PAIRING_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PEHP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pehp assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PEHP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pehp assertion failed");

`endif

[design/pehp_pkg.sv]
// Package with types, register codes and constants of the paddle end hit pairing core.
package pehp_pkg;

    localparam int MAX_HITS_DEF = 16;
    localparam int NUM_BARS_DEF = 16;
    localparam int MAX_RESULTS = 64;
    localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);

    localparam int CFG_IDX_W = 4;
    localparam int MUL_W = 39;

    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_THRESHOLD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTENUATION_GAIN = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_LIGHT_SPEED = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_TRANSIT_TIME = 4'd3;

    localparam logic [15:0] ENERGY_THRESHOLD_RST = 16'd500;
    localparam logic [15:0] ATTENUATION_GAIN_RST = 16'd19035;
    localparam logic [15:0] HALF_LIGHT_SPEED_RST = 16'd19200;
    localparam logic [15:0] HALF_TRANSIT_TIME_RST = 16'd64;

    typedef struct packed {
        logic [4:0]         bar;
        logic               end_req;
        logic [15:0]        energy;
        logic signed [19:0] time_req;
        logic               last_hit;
    } hit_t;

    typedef struct packed {
        logic               point_valid;
        logic [4:0]         point_bar;
        logic signed [19:0] point_time;
        logic signed [15:0] position_offset;
        logic [17:0]        point_energy;
        logic               overflow;
        logic               last_point;
    } point_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [15:0]          value;
    } cfg_req_t;

    typedef struct packed {
        logic [15:0] energy_threshold;
        logic [15:0] attenuation_gain;
        logic [15:0] half_light_speed;
        logic [15:0] half_transit_time;
    } cfg_regs_t;

    typedef struct packed {
        logic [4:0]         bar;
        logic               end_req;
        logic [15:0]        energy;
        logic signed [19:0] time_req;
    } entry_t;

endpackage

[design/pehp_stream_if.sv]
// Valid/ready channel interface carrying one request payload of a given type.
interface pehp_stream_if #(
    parameter type T = logic
) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

[design/paddle_end_hit_pairing_core.sv]
// Top level of the paddle end hit pairing core: configuration registers and unit wiring.
//
// Channel  Dir  Payload                          Request taken when
// hit      in   bar, end_req, energy, time_req   hit.valid && hit.ready
// point    out  point fields, overflow, last     point.valid && point.ready
// cfg      in   register index, 16-bit value     cfg.valid && cfg.ready
//
// A hit without the last mark is taken in the idle state, which the block keeps, so it stays ready.
// On the last hit the block walks all pairs: each is addressed and loaded; an opposite-end pair
// on one bar also runs the 16 steps of the square root unit, then scaling, energy and position.
// The walk stalls while a point waits in the output register and another in the pending one.
// Reset is asynchronous and needs no clearing pass; the hit buffer is never read before written.
module paddle_end_hit_pairing_core #(
    parameter int MAX_HITS = pehp_pkg::MAX_HITS_DEF,
    parameter int NUM_BARS = pehp_pkg::NUM_BARS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    pehp_stream_if.sink   hit,
    pehp_stream_if.source point,
    pehp_stream_if.sink   cfg
);
    import pehp_pkg::*;

    localparam int IDX_W = $clog2(MAX_HITS);

    cfg_regs_t          cfg_reg;
    logic               st_wr_en;
    logic [IDX_W-1:0]   st_wr_addr;
    entry_t             st_wr_data;
    logic [IDX_W-1:0]   st_rd_addr_a;
    logic [IDX_W-1:0]   st_rd_addr_b;
    entry_t             st_rd_data_a;
    entry_t             st_rd_data_b;
    logic               sqrt_start;
    logic [31:0]        sqrt_radicand;
    logic               sqrt_done;
    logic [15:0]        sqrt_root;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.energy_threshold  <= ENERGY_THRESHOLD_RST;
            cfg_reg.attenuation_gain  <= ATTENUATION_GAIN_RST;
            cfg_reg.half_light_speed  <= HALF_LIGHT_SPEED_RST;
            cfg_reg.half_transit_time <= HALF_TRANSIT_TIME_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.data.index)
                CFG_ENERGY_THRESHOLD:  cfg_reg.energy_threshold  <= cfg.data.value;
                CFG_ATTENUATION_GAIN:  cfg_reg.attenuation_gain  <= cfg.data.value;
                CFG_HALF_LIGHT_SPEED:  cfg_reg.half_light_speed  <= cfg.data.value;
                CFG_HALF_TRANSIT_TIME: cfg_reg.half_transit_time <= cfg.data.value;
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    pehp_hit_store #(
        .DEPTH (MAX_HITS)
    ) u_store (
        .clk       (clk),
        .wr_en     (st_wr_en),
        .wr_addr   (st_wr_addr),
        .wr_data   (st_wr_data),
        .rd_addr_a (st_rd_addr_a),
        .rd_addr_b (st_rd_addr_b),
        .rd_data_a (st_rd_data_a),
        .rd_data_b (st_rd_data_b)
    );

    pehp_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_radicand),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    pehp_pair_seq #(
        .MAX_HITS (MAX_HITS),
        .NUM_BARS (NUM_BARS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .hit           (hit),
        .point         (point),
        .cfg_regs      (cfg_reg),
        .st_wr_en      (st_wr_en),
        .st_wr_addr    (st_wr_addr),
        .st_wr_data    (st_wr_data),
        .st_rd_addr_a  (st_rd_addr_a),
        .st_rd_addr_b  (st_rd_addr_b),
        .st_rd_data_a  (st_rd_data_a),
        .st_rd_data_b  (st_rd_data_b),
        .sqrt_start    (sqrt_start),
        .sqrt_radicand (sqrt_radicand),
        .sqrt_done     (sqrt_done),
        .sqrt_root     (sqrt_root)
    );

endmodule

[design/pehp_hit_store.sv]
// Hit buffer memory with one write port and two registered read ports.
module pehp_hit_store #(
    parameter int DEPTH = pehp_pkg::MAX_HITS_DEF,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  pehp_pkg::entry_t     wr_data,
    input  logic [IDX_W-1:0]     rd_addr_a,
    input  logic [IDX_W-1:0]     rd_addr_b,
    output pehp_pkg::entry_t     rd_data_a,
    output pehp_pkg::entry_t     rd_data_b
);
    import pehp_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_a_reg;
    entry_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

[design/pehp_isqrt.sv]
// Iterative integer square root of a 32-bit value, two radicand bits per cycle.
module pehp_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] radicand,
    output logic        done,
    output logic [15:0] root
);
    import pehp_pkg::*;

    logic [31:0] rad_reg;
    logic [19:0] rem_reg;
    logic [15:0] root_reg;
    logic [3:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [19:0] rem_sh;
    logic [19:0] trial;
    logic        fits;

    assign rem_sh = {rem_reg[17:0], rad_reg[31:30]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rad_reg  <= {rad_reg[29:0], 2'b00};
                rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
                root_reg <= {root_reg[14:0], fits};
                step_reg <= step_reg + 4'd1;
                if (step_reg == 4'hF)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[design/pehp_pair_seq.sv]
// Sequencer that stores hits, walks hit pairs through the shared multiplier and emits points.
`include "paddle_end_hit_pairing_core_defines.svh"

module pehp_pair_seq #(
    parameter int MAX_HITS = pehp_pkg::MAX_HITS_DEF,
    parameter int NUM_BARS = pehp_pkg::NUM_BARS_DEF,
    localparam int IDX_W = $clog2(MAX_HITS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    pehp_stream_if.sink           hit,
    pehp_stream_if.source         point,
    input  pehp_pkg::cfg_regs_t   cfg_regs,
    output logic                  st_wr_en,
    output logic [IDX_W-1:0]      st_wr_addr,
    output pehp_pkg::entry_t      st_wr_data,
    output logic [IDX_W-1:0]      st_rd_addr_a,
    output logic [IDX_W-1:0]      st_rd_addr_b,
    input  pehp_pkg::entry_t      st_rd_data_a,
    input  pehp_pkg::entry_t      st_rd_data_b,
    output logic                  sqrt_start,
    output logic [31:0]           sqrt_radicand,
    input  logic                  sqrt_done,
    input  logic [15:0]           sqrt_root
);
    import pehp_pkg::*;

    localparam int CNT_W = $clog2(MAX_HITS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADDR,
        S_LOAD,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_SCALE,
        S_ENERGY,
        S_POS,
        S_FINISH
    } state_t;

    state_t                state_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  ovf_reg;
    logic [CNT_W-1:0]      i_reg;
    logic [CNT_W-1:0]      j_reg;
    logic [RES_CNT_W-1:0]  n_reg;
    logic [17:0]           energy_reg;
    point_t                pend_reg;
    logic                  pend_valid_reg;
    point_t                out_reg;
    logic                  out_valid_reg;
    logic signed [MUL_W-1:0] mul_reg;

    logic                  hit_acc;
    logic                  bar_ok;
    logic                  has_room;
    logic                  slot_free;
    logic                  out_load;
    logic                  pair_match;
    logic                  mul_en;
    logic [15:0]           mul_a;
    logic signed [21:0]    mul_b;
    logic signed [20:0]    dt;
    logic [32:0]           esum;
    logic [17:0]           ecalc;
    logic                  e_pass;
    logic signed [22:0]    tsum;
    logic signed [22:0]    thalf;
    logic signed [19:0]    tsat;
    logic signed [MUL_W:0] psum;
    logic signed [MUL_W:0] pq;
    logic signed [15:0]    ysat;
    logic [CNT_W:0]        i_plus2;
    point_t                new_pt;
    point_t                empty_pt;
    point_t                fin_pt;

    assign hit.ready  = (state_reg == S_IDLE);
    assign hit_acc    = hit.valid && hit.ready;
    assign bar_ok     = (hit.data.bar != '0) && (int'(hit.data.bar) <= NUM_BARS);
    assign has_room   = (cnt_reg < CNT_W'(MAX_HITS));
    assign slot_free  = !out_valid_reg || point.ready;
    assign out_load   = slot_free && (((state_reg == S_POS) && pend_valid_reg)
                                      || (state_reg == S_FINISH));

    assign st_wr_en            = hit_acc && bar_ok && has_room;
    assign st_wr_addr          = cnt_reg[IDX_W-1:0];
    assign st_wr_data.bar      = hit.data.bar;
    assign st_wr_data.end_req  = hit.data.end_req;
    assign st_wr_data.energy   = hit.data.energy;
    assign st_wr_data.time_req = hit.data.time_req;
    assign st_rd_addr_a        = i_reg[IDX_W-1:0];
    assign st_rd_addr_b        = j_reg[IDX_W-1:0];

    assign pair_match = (st_rd_data_a.bar == st_rd_data_b.bar)
                        && (st_rd_data_a.end_req != st_rd_data_b.end_req);

    assign sqrt_start    = (state_reg == S_SQRT_GO);
    assign sqrt_radicand = mul_reg[31:0];

    assign dt = st_rd_data_a.end_req
                ? (21'(st_rd_data_a.time_req) - 21'(st_rd_data_b.time_req))
                : (21'(st_rd_data_b.time_req) - 21'(st_rd_data_a.time_req));

    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = st_rd_data_a.energy;
        mul_b  = $signed({6'b000000, st_rd_data_b.energy});
        unique case (state_reg)
            S_LOAD:
            begin
                mul_en = 1'b1;
            end
            S_SCALE:
            begin
                mul_en = 1'b1;
                mul_a  = sqrt_root;
                mul_b  = $signed({6'b000000, cfg_regs.attenuation_gain});
            end
            S_ENERGY:
            begin
                mul_en = 1'b1;
                mul_a  = cfg_regs.half_light_speed;
                mul_b  = 22'(dt);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            mul_reg <= MUL_W'($signed({1'b0, mul_a})) * MUL_W'(mul_b);
        end
    end

    assign esum   = mul_reg[32:0] + 33'd8192;
    assign ecalc  = esum[32] ? 18'h3FFFF : esum[31:14];
    assign e_pass = (ecalc > {2'b00, cfg_regs.energy_threshold})
                    && (n_reg < RES_CNT_W'(MAX_RESULTS));

    assign tsum  = 23'(st_rd_data_a.time_req) + 23'(st_rd_data_b.time_req)
                   - $signed({6'b000000, cfg_regs.half_transit_time, 1'b0}) + 23'sd1;
    assign thalf = tsum >>> 1;
    assign tsat  = (thalf > 23'sd524287) ? 20'sd524287
                 : (thalf < -23'sd524288) ? -20'sd524288
                 : thalf[19:0];

    assign psum = (MUL_W+1)'(mul_reg) + (MUL_W+1)'(2048);
    assign pq   = psum >>> 12;
    assign ysat = (pq > (MUL_W+1)'(32767)) ? 16'sd32767
                : (pq < -(MUL_W+1)'(32768)) ? -16'sd32768
                : pq[15:0];

    assign i_plus2 = {1'b0, i_reg} + (CNT_W+1)'(2);

    always_comb
    begin
        new_pt.point_valid     = 1'b1;
        new_pt.point_bar       = st_rd_data_a.bar;
        new_pt.point_time      = tsat;
        new_pt.position_offset = ysat;
        new_pt.point_energy    = energy_reg;
        new_pt.overflow        = ovf_reg;
        new_pt.last_point      = 1'b0;
        empty_pt               = '0;
        empty_pt.overflow      = ovf_reg;
        empty_pt.last_point    = 1'b1;
        fin_pt                 = pend_reg;
        fin_pt.last_point      = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            n_reg          <= '0;
            energy_reg     <= '0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (point.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (hit_acc)
                    begin
                        if (bar_ok)
                        begin
                            if (has_room)
                            begin
                                cnt_reg <= cnt_reg + CNT_W'(1);
                            end
                            else
                            begin
                                ovf_reg <= 1'b1;
                            end
                        end
                        if (hit.data.last_hit)
                        begin
                            i_reg     <= '0;
                            j_reg     <= CNT_W'(1);
                            state_reg <= S_ADDR;
                        end
                    end
                end
                S_ADDR:
                begin
                    if (j_reg >= cnt_reg)
                    begin
                        if (i_plus2 >= {1'b0, cnt_reg})
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            i_reg <= i_reg + CNT_W'(1);
                            j_reg <= i_plus2[CNT_W-1:0];
                        end
                    end
                    else
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    if (pair_match)
                    begin
                        state_reg <= S_SQRT_GO;
                    end
                    else
                    begin
                        j_reg     <= j_reg + CNT_W'(1);
                        state_reg <= S_ADDR;
                    end
                end
                S_SQRT_GO:
                begin
                    state_reg <= S_SQRT_WAIT;
                end
                S_SQRT_WAIT:
                begin
                    if (sqrt_done)
                    begin
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE:
                begin
                    state_reg <= S_ENERGY;
                end
                S_ENERGY:
                begin
                    if (e_pass)
                    begin
                        energy_reg <= ecalc;
                        state_reg  <= S_POS;
                    end
                    else
                    begin
                        j_reg     <= j_reg + CNT_W'(1);
                        state_reg <= S_ADDR;
                    end
                end
                S_POS:
                begin
                    if (!pend_valid_reg || slot_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_reg <= pend_reg;
                        end
                        pend_reg       <= new_pt;
                        pend_valid_reg <= 1'b1;
                        n_reg          <= n_reg + RES_CNT_W'(1);
                        j_reg          <= j_reg + CNT_W'(1);
                        state_reg      <= S_ADDR;
                    end
                end
                S_FINISH:
                begin
                    if (slot_free)
                    begin
                        out_reg        <= pend_valid_reg ? fin_pt : empty_pt;
                        pend_valid_reg <= 1'b0;
                        n_reg          <= '0;
                        cnt_reg        <= '0;
                        ovf_reg        <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign point.valid = out_valid_reg;
    assign point.data  = out_reg;

    `PEHP_ASSERT_IMPL(a_pend_counted, pend_valid_reg, n_reg != '0)
    `PEHP_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(MAX_HITS))
    `PEHP_ASSERT_IMPL(a_results_bound, 1'b1, n_reg <= RES_CNT_W'(MAX_RESULTS))
    `PEHP_ASSERT_NEXT(a_finish_clears, (state_reg == S_FINISH) && slot_free, (cnt_reg == '0) && !ovf_reg && (state_reg == S_IDLE) && out_valid_reg)

endmodule

[dv/paddle_end_hit_pairing_core_tb.sv]
// Self-checking testbench that pairs paddle end hits in its own predictor and checks every point.
module paddle_end_hit_pairing_core_tb;

    import pehp_pkg::*;

    localparam int MAX_HITS = MAX_HITS_DEF;
    localparam int NUM_BARS = NUM_BARS_DEF;
    localparam int RANDOM_HITS = 420;
    localparam int RANDOM_PHASES = 8;
    localparam int SETTLE_CYCLES = 2000;
    localparam int LONG_HOLD = 600;
    localparam longint CYCLE_LIMIT = 1000000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_HALF_TRANSIT_TIME + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;

    localparam longint unsigned ENERGY_MAX = 262143;
    localparam longint TIME_MIN = -524288;
    localparam longint TIME_MAX = 524287;
    localparam longint OFFSET_MIN = -32768;
    localparam longint OFFSET_MAX = 32767;

    localparam point_t EMPTY_EVENT = '{1'b0, 5'd0, 20'sd0, 16'sd0, 18'd0, 1'b0, 1'b1};
    localparam point_t CENTERED_POINT = '{1'b1, 5'd5, 20'sd936, 16'sd0, 18'd19035, 1'b0, 1'b1};

    typedef enum {DRAIN_FREE, DRAIN_LIGHT, DRAIN_THIRDS, DRAIN_HEAVY} drain_mode_t;

    typedef struct {
        hit_t   hit;
        int     copies;
        bit     typed;
        point_t want;
    } script_row_t;

    script_row_t opening_rows [15] = '{
        '{'{5'd3, 1'b0, 16'd0, 20'sd0, 1'b1}, 1, 1'b1, EMPTY_EVENT},
        '{'{5'd0, 1'b1, 16'hFFFF, 20'h7FFFF, 1'b1}, 1, 1'b1, EMPTY_EVENT},
        '{'{5'd5, 1'b0, 16'd16384, 20'sd1000, 1'b0}, 1, 1'b0, '0},
        '{'{5'd5, 1'b1, 16'd16384, 20'sd1000, 1'b1}, 1, 1'b1, CENTERED_POINT},
        '{'{5'd16, 1'b1, 16'hFFFF, 20'h7FFFF, 1'b0}, 1, 1'b0, '0},
        '{'{5'd16, 1'b0, 16'hFFFF, 20'h80000, 1'b1}, 1, 1'b0, '0},
        '{'{5'd1, 1'b0, 16'hFFFF, 20'h80000, 1'b0}, 1, 1'b0, '0},
        '{'{5'd1, 1'b1, 16'hFFFF, 20'h80000, 1'b1}, 1, 1'b0, '0},
        '{'{5'd31, 1'b1, 16'hFFFF, 20'h7FFFF, 1'b1}, 1, 1'b1, EMPTY_EVENT},
        '{'{5'd4, 1'b0, 16'd900, 20'sd100, 1'b0}, 1, 1'b0, '0},
        '{'{5'd4, 1'b1, 16'd900, 20'sd50, 1'b0}, 1, 1'b0, '0},
        '{'{5'd4, 1'b0, 16'd800, -20'sd30, 1'b0}, 12, 1'b0, '0},
        '{'{5'd6, 1'b0, 16'd400, 20'sd0, 1'b0}, 1, 1'b0, '0},
        '{'{5'd6, 1'b1, 16'd400, 20'sd0, 1'b0}, 1, 1'b0, '0},
        '{'{5'd4, 1'b1, 16'd700, 20'sd70, 1'b1}, 1, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    pehp_stream_if #(.T(hit_t)) hit_ch ();
    pehp_stream_if #(.T(point_t)) point_ch ();
    pehp_stream_if #(.T(cfg_req_t)) cfg_ch ();

    paddle_end_hit_pairing_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .hit   (hit_ch),
        .point (point_ch),
        .cfg   (cfg_ch)
    );

    cfg_regs_t regs_model;
    entry_t    held_hits [MAX_HITS];
    int        held_count = 0;
    bit        held_overflow = 1'b0;
    point_t    event_points [$];
    point_t    expected_points [$];

    int errors = 0;
    int hits_sent = 0;
    int events_sent = 0;
    int points_seen = 0;
    int empties_seen = 0;
    int overflow_seen = 0;
    int cfg_writes = 0;
    int settings_run = 1;
    int burst_left = 0;
    int gap_max = 3;
    int holds_asked = 0;
    longint cycle_count = 0;

    always #1 clk = ~clk;

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 15; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    task automatic absorb_hit(input hit_t h);
        point_t p;
        longint unsigned root;
        longint unsigned energy;
        longint ti;
        longint tj;
        longint stamp;
        longint spread;
        longint offset;
        event_points.delete();
        if (h.bar >= 1 && h.bar <= NUM_BARS)
        begin
            if (held_count < MAX_HITS)
            begin
                held_hits[held_count] = '{h.bar, h.end_req, h.energy, h.time_req};
                held_count++;
            end
            else
                held_overflow = 1'b1;
        end
        if (!h.last_hit)
            return;
        for (int i = 0; i < held_count; i++)
            for (int j = i + 1; j < held_count; j++)
            begin
                if (held_hits[i].bar != held_hits[j].bar
                    || held_hits[i].end_req == held_hits[j].end_req)
                    continue;
                root = floor_root(64'(held_hits[i].energy) * 64'(held_hits[j].energy));
                energy = (root * 64'(regs_model.attenuation_gain) + 64'd8192) >> 14;
                if (energy > ENERGY_MAX)
                    energy = ENERGY_MAX;
                if (energy <= 64'(regs_model.energy_threshold)
                    || event_points.size() >= MAX_RESULTS)
                    continue;
                ti = longint'(held_hits[i].time_req);
                tj = longint'(held_hits[j].time_req);
                stamp = clamp((ti + tj - 2 * longint'(regs_model.half_transit_time) + 1) >>> 1,
                              TIME_MIN, TIME_MAX);
                spread = longint'(regs_model.half_light_speed)
                         * (held_hits[i].end_req ? ti - tj : tj - ti);
                offset = clamp((spread + 2048) >>> 12, OFFSET_MIN, OFFSET_MAX);
                p.point_valid = 1'b1;
                p.point_bar = held_hits[i].bar;
                p.point_time = stamp[19:0];
                p.position_offset = offset[15:0];
                p.point_energy = energy[17:0];
                p.overflow = held_overflow;
                p.last_point = 1'b0;
                event_points.insert(event_points.size(), p);
            end
        if (event_points.size() == 0)
        begin
            p = EMPTY_EVENT;
            p.overflow = held_overflow;
            event_points.insert(event_points.size(), p);
        end
        else
            event_points[event_points.size() - 1].last_point = 1'b1;
        held_count = 0;
        held_overflow = 1'b0;
    endtask

    task automatic idle_hits(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            hit_ch.valid <= 1'b0;
        end
    endtask

    task automatic send_hit(input hit_t h, input bit typed, input point_t want);
        if (burst_left == 0)
        begin
            idle_hits($urandom_range(0, gap_max));
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        hit_ch.valid <= 1'b1;
        hit_ch.data <= h;
        do
            @(posedge clk);
        while (!hit_ch.ready);
        hits_sent++;
        absorb_hit(h);
        if (h.last_hit)
            events_sent++;
        if (typed && h.last_hit)
            expected_points.insert(expected_points.size(), want);
        else
            foreach (event_points[k])
                expected_points.insert(expected_points.size(), event_points[k]);
    endtask

    task automatic drain_points();
        idle_hits(1);
        while (expected_points.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [15:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= cfg_req_t'{index, value};
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_writes++;
        case (index)
            CFG_ENERGY_THRESHOLD: regs_model.energy_threshold = value;
            CFG_ATTENUATION_GAIN: regs_model.attenuation_gain = value;
            CFG_HALF_LIGHT_SPEED: regs_model.half_light_speed = value;
            CFG_HALF_TRANSIT_TIME: regs_model.half_transit_time = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic apply_setting(input cfg_regs_t setting);
        logic [CFG_IDX_W-1:0] spare_index;
        drain_points();
        repeat (SETTLE_CYCLES) @(posedge clk);
        spare_index = $urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI);
        write_reg(spare_index, 16'($urandom));
        write_reg(CFG_ENERGY_THRESHOLD, setting.energy_threshold);
        write_reg(CFG_ATTENUATION_GAIN, setting.attenuation_gain);
        write_reg(CFG_HALF_LIGHT_SPEED, setting.half_light_speed);
        write_reg(CFG_HALF_TRANSIT_TIME, setting.half_transit_time);
        settings_run++;
    endtask

    task automatic send_event(input bit dense);
        hit_t h;
        logic [4:0] bars [3];
        int n;
        bit wide;
        longint base;
        foreach (bars[b])
            bars[b] = 5'($urandom_range(1, NUM_BARS));
        if (dense)
            n = MAX_HITS;
        else if ($urandom_range(0, 99) < 8)
            n = $urandom_range(MAX_HITS - 2, MAX_HITS + 4);
        else
            n = $urandom_range(1, 8);
        wide = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 9))
            0: base = TIME_MAX - 200;
            1: base = TIME_MIN + 200;
            default: base = longint'($urandom_range(0, 8000)) - 4000;
        endcase
        for (int k = 0; k < n; k++)
        begin
            h.bar = bars[$urandom_range(0, 2)];
            if ($urandom_range(0, 19) == 0)
                h.bar = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(NUM_BARS + 1, 31));
            h.end_req = 1'($urandom);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: h.energy = 16'($urandom);
                4, 5, 6: h.energy = 16'($urandom_range(0, 2000));
                default: h.energy = 16'($urandom_range(30000, 65535));
            endcase
            if (dense)
            begin
                h.bar = bars[0];
                h.end_req = k[0];
                h.energy = 16'($urandom_range(20000, 65535));
            end
            if (wide)
                h.time_req = 20'($urandom);
            else
                h.time_req = 20'(base + longint'($urandom_range(0, 600)) - 300);
            h.last_hit = (k == n - 1);
            send_hit(h, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t timeout, %0d point requests still awaited", $time,
                     expected_points.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : point_drain
        int hold_left;
        int holds_done;
        int mode_left;
        int tick;
        drain_mode_t mode;
        hold_left = 0;
        holds_done = 0;
        mode_left = 0;
        tick = 0;
        mode = DRAIN_FREE;
        point_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done != holds_asked)
            begin
                holds_done = holds_asked;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                mode = drain_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                point_ch.ready <= 1'b0;
            end
            else
                case (mode)
                    DRAIN_FREE: point_ch.ready <= 1'b1;
                    DRAIN_LIGHT: point_ch.ready <= ($urandom_range(0, 3) != 0);
                    DRAIN_THIRDS: point_ch.ready <= (tick % 3 == 0);
                    default: point_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
        end
    end

    always @(posedge clk)
    begin : point_check
        point_t want;
        point_t got;
        if (rst_n && point_ch.valid && point_ch.ready)
        begin
            got = point_ch.data;
            if (expected_points.size() == 0)
            begin
                errors++;
                $display("%0t unexpected point request: expected none actual %p", $time, got);
            end
            else
            begin
                want = expected_points.pop_front();
                check_field("point_valid", want.point_valid, got.point_valid);
                check_field("point_bar", want.point_bar, got.point_bar);
                check_field("point_time", want.point_time, got.point_time);
                check_field("position_offset", want.position_offset, got.position_offset);
                check_field("point_energy", want.point_energy, got.point_energy);
                check_field("overflow", want.overflow, got.overflow);
                check_field("last_point", want.last_point, got.last_point);
                if (got.point_valid)
                    points_seen++;
                else
                    empties_seen++;
                if (got.overflow && got.last_point)
                    overflow_seen++;
            end
        end
    end

    initial
    begin : stimulus
        cfg_regs_t setting;
        int phase_start;
        rst_n = 1'b0;
        hit_ch.valid = 1'b0;
        hit_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        regs_model = '{ENERGY_THRESHOLD_RST, ATTENUATION_GAIN_RST,
                       HALF_LIGHT_SPEED_RST, HALF_TRANSIT_TIME_RST};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (opening_rows[r])
            repeat (opening_rows[r].copies)
                send_hit(opening_rows[r].hit, opening_rows[r].typed, opening_rows[r].want);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: setting = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
                1: setting = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                2: setting = '{16'd0, 16'd16384, 16'd256, 16'd0};
                3: setting = '{ENERGY_THRESHOLD_RST, ATTENUATION_GAIN_RST,
                               HALF_LIGHT_SPEED_RST, HALF_TRANSIT_TIME_RST};
                default: setting = '{16'($urandom_range(0, 3000)), 16'($urandom),
                                     16'($urandom), 16'($urandom_range(0, 2000))};
            endcase
            apply_setting(setting);
            gap_max = (p % 3 == 0) ? 0 : $urandom_range(2, 10);
            phase_start = hits_sent;
            if (p == 2)
            begin
                holds_asked++;
                send_event(1'b1);
            end
            if (p == 5)
                send_event(1'b1);
            while (hits_sent - phase_start < RANDOM_HITS / RANDOM_PHASES)
            begin
                send_event(1'b0);
                if ($urandom_range(0, 19) == 0)
                    drain_points();
            end
        end

        drain_points();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d hits in %0d events under %0d register settings, %0d writes.",
                 hits_sent, events_sent, settings_run, cfg_writes);
        $display("Checked %0d points, %0d empty events, %0d events with dropped hits.",
                 points_seen, empties_seen, overflow_seen);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
